/* rtl/bae_pkg.sv */
// Shared types, constants and the angle pair table for the bond angle enumerator.
`default_nettype none
package bae_pkg;

    localparam int unsigned IdWidth         = 16;
    localparam int unsigned TypeWidth       = 10;
    localparam int unsigned OrderWidth      = 4;
    localparam int unsigned KeepDepth       = 5;
    localparam int unsigned NbrCountWidth   = 6;
    localparam int unsigned AngleCountWidth = 17;
    localparam int unsigned StepWidth       = 4;
    localparam int unsigned SelWidth        = 3;

    localparam logic [NbrCountWidth-1:0]   MaxNeighborSlots = NbrCountWidth'(16);
    localparam logic [AngleCountWidth-1:0] MaxAngles        = AngleCountWidth'(65536);
    localparam logic [AngleCountWidth-1:0] AngleCountMax    = '1;
    localparam logic [OrderWidth-1:0]      CoordBond        = OrderWidth'(9);
    localparam logic [TypeWidth-1:0]       TypeLimit        = TypeWidth'(300);

    typedef logic [IdWidth-1:0] id_t;
    typedef id_t [KeepDepth-1:0] nbr_arr_t;

    // one atom's worth of work handed from front to back
    typedef struct packed {
        logic        clear;
        logic [2:0]  count;
        id_t         center;
        nbr_arr_t    nbr;
    } job_t;

    // which kept neighbors form one record
    typedef struct packed {
        logic [SelWidth-1:0] first;
        logic [SelWidth-1:0] second;
        logic [SelWidth-1:0] fourth;
        logic                has_fourth;
        logic                last;
    } pair_sel_t;

    function automatic pair_sel_t pair_sel(input logic [2:0] count,
                                           input logic [StepWidth-1:0] step);
        pair_sel_t s;
        s = '0;
        unique case (count)
            3'd2:
            begin
                s.first  = 3'd0;
                s.second = 3'd1;
                s.last   = 1'b1;
            end
            3'd3:
            begin
                s.has_fourth = 1'b1;
                case (step)
                    4'd0:
                    begin
                        s.first = 3'd0; s.second = 3'd1; s.fourth = 3'd2;
                    end
                    4'd1:
                    begin
                        s.first = 3'd0; s.second = 3'd2; s.fourth = 3'd1;
                    end
                    default:
                    begin
                        s.first = 3'd1; s.second = 3'd2; s.fourth = 3'd0;
                        s.last  = 1'b1;
                    end
                endcase
            end
            3'd4:
            begin
                case (step)
                    4'd0:    begin s.first = 3'd0; s.second = 3'd1; end
                    4'd1:    begin s.first = 3'd0; s.second = 3'd2; end
                    4'd2:    begin s.first = 3'd0; s.second = 3'd3; end
                    4'd3:    begin s.first = 3'd1; s.second = 3'd2; end
                    4'd4:    begin s.first = 3'd1; s.second = 3'd3; end
                    default:
                    begin
                        s.first = 3'd2; s.second = 3'd3; s.last = 1'b1;
                    end
                endcase
            end
            default:
            begin
                case (step)
                    4'd0:    begin s.first = 3'd0; s.second = 3'd1; end
                    4'd1:    begin s.first = 3'd0; s.second = 3'd2; end
                    4'd2:    begin s.first = 3'd0; s.second = 3'd3; end
                    4'd3:    begin s.first = 3'd0; s.second = 3'd4; end
                    4'd4:    begin s.first = 3'd1; s.second = 3'd2; end
                    4'd5:    begin s.first = 3'd1; s.second = 3'd3; end
                    4'd6:    begin s.first = 3'd1; s.second = 3'd4; end
                    4'd7:    begin s.first = 3'd2; s.second = 3'd3; end
                    4'd8:    begin s.first = 3'd2; s.second = 3'd4; end
                    default:
                    begin
                        s.first = 3'd3; s.second = 3'd4; s.last = 1'b1;
                    end
                endcase
            end
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

/* rtl/bae_slot_if.sv */
// Input channel: one neighbor slot word per handshake.
`default_nettype none
interface bae_slot_if
    import bae_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  first_of_run;
    logic [IdWidth-1:0]    atom_index;
    logic [TypeWidth-1:0]  atom_type;
    logic [IdWidth-1:0]    neighbor_id;
    logic [OrderWidth-1:0] bond_order;
    logic                  last_slot;

    modport source (output valid, first_of_run, atom_index, atom_type, neighbor_id,
                    bond_order, last_slot, input ready);
    modport sink (input valid, first_of_run, atom_index, atom_type, neighbor_id,
                  bond_order, last_slot, output ready);
endinterface
`default_nettype wire

/* rtl/bae_angle_if.sv */
// Output channel: one angle record word per handshake.
`default_nettype none
interface bae_angle_if
    import bae_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [IdWidth-1:0] angle_index;
    logic [IdWidth-1:0] end_first;
    logic [IdWidth-1:0] center_atom;
    logic [IdWidth-1:0] end_second;
    logic [IdWidth-1:0] fourth_atom;
    logic               last_of_atom;
    logic               overflow;

    modport source (output valid, angle_index, end_first, center_atom, end_second,
                    fourth_atom, last_of_atom, overflow, input ready);
    modport sink (input valid, angle_index, end_first, center_atom, end_second,
                  fourth_atom, last_of_atom, overflow, output ready);
endinterface
`default_nettype wire

/* rtl/bond_angle_enumerator_unit.sv */
// Top level of the bond angle enumerator: front end, job queue, back end.
//
// Usage:
//   slot  : one neighbor slot word per handshake (valid/ready). Slots of an
//           atom arrive in order; last_slot marks the atom's final slot and
//           first_of_run restarts the running angle index.
//   angle : one angle record word per handshake (valid/ready).
// The front end takes a slot every cycle while the two-entry job queue has
// room. An atom that yields records is queued on its last slot; the back end
// emits one record per cycle from its output register while the receiver is
// ready; an atom yields N records (1, 3, 6 or 10). A job passes through the
// queue and into the back end's job register before its first record is
// registered for output. Sustained rate is set by the back end's record loop.
// When the receiver stalls, the output register holds its word, the back end
// waits, and the queue fills before the slot channel drops ready.
// Reset clears the neighbor count, the angle count, the queue and the output
// valid; no clearing pass is needed.
`default_nettype none
module bond_angle_enumerator_unit
    import bae_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    bae_slot_if.sink    slot,
    bae_angle_if.source angle
);
    job_t push_job, pop_job;
    logic push, full, not_empty, pop;

    bae_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .slot  (slot),
        .job   (push_job),
        .push  (push),
        .full  (full)
    );

    bae_job_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_job    (push_job),
        .push      (push),
        .full      (full),
        .rd_job    (pop_job),
        .not_empty (not_empty),
        .pop       (pop)
    );

    bae_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_in    (pop_job),
        .job_valid (not_empty),
        .pop       (pop),
        .angle     (angle)
    );
endmodule
`default_nettype wire

/* rtl/bae_front.sv */
// Front end: collects an atom's neighbors and queues a job on its last slot.
`default_nettype none
module bae_front
    import bae_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    bae_slot_if.sink    slot,
    output job_t        job,
    output logic        push,
    input  wire logic   full
);
    logic [NbrCountWidth-1:0] count_reg, count_next;
    logic [NbrCountWidth-1:0] base;
    logic                     clear_reg, clear_next;
    nbr_arr_t                 keep_reg;
    nbr_arr_t                 nbr_now;
    logic                     accept;
    logic                     qualify;
    logic                     emits;

    assign slot.ready = !full;
    assign accept     = slot.valid && slot.ready;

    always_comb
    begin
        base    = slot.first_of_run ? '0 : count_reg;
        qualify = (slot.neighbor_id != '0) && (slot.bond_order != CoordBond);
        for (int k = 0; k < KeepDepth; k++)
        begin
            nbr_now[k] = (qualify && base == NbrCountWidth'(k)) ? slot.neighbor_id
                                                                : keep_reg[k];
        end
        count_next = base;
        if (qualify && base < MaxNeighborSlots)
        begin
            count_next = base + NbrCountWidth'(1);
        end
        emits = slot.last_slot && (slot.atom_type < TypeLimit)
                && count_next >= NbrCountWidth'(2) && count_next <= NbrCountWidth'(KeepDepth);
        // hold a pending clear of the angle count until a job carries it
        clear_next = clear_reg || slot.first_of_run;
        if (emits)
        begin
            clear_next = 1'b0;
        end
        if (slot.last_slot)
        begin
            count_next = '0;
        end
    end

    assign push       = accept && emits;
    assign job.clear  = clear_reg || slot.first_of_run;
    assign job.count  = count_next == '0 ? 3'(base + NbrCountWidth'(qualify)) : 3'd0;
    assign job.center = slot.atom_index;
    assign job.nbr    = nbr_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            clear_reg <= 1'b0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            clear_reg <= clear_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            keep_reg <= nbr_now;
        end
    end
endmodule
`default_nettype wire

/* rtl/bae_job_fifo.sv */
// Two-entry queue of jobs between front and back.
`default_nettype none
module bae_job_fifo
    import bae_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire job_t wr_job,
    input  wire logic push,
    output logic      full,
    output job_t      rd_job,
    output logic      not_empty,
    input  wire logic pop
);
    job_t       mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full      = fill_reg == 2'd2;
    assign not_empty = fill_reg != 2'd0;
    assign rd_job    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

/* rtl/bae_back.sv */
// Back end: steps through a job's neighbor pairs, one record per cycle unless stalled.
`default_nettype none
module bae_back
    import bae_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire job_t  job_in,
    input  wire logic  job_valid,
    output logic       pop,
    bae_angle_if.source angle
);
    job_t                       job_reg;
    logic                       busy_reg;
    logic [StepWidth-1:0]       step_reg;
    logic [AngleCountWidth-1:0] acount_reg, acount_next;
    logic [AngleCountWidth-1:0] cur;
    logic                       out_valid_reg;
    logic [IdWidth-1:0]         index_reg, first_reg, center_reg, second_reg, fourth_reg;
    logic                       last_reg, ovf_reg;
    pair_sel_t                  sel;
    logic                       emit, fin;

    assign sel  = pair_sel(job_reg.count, step_reg);
    assign emit = busy_reg && (!out_valid_reg || angle.ready);
    assign fin  = emit && sel.last;
    assign pop  = job_valid && (!busy_reg || fin);

    always_comb
    begin
        cur = (step_reg == '0 && job_reg.clear) ? '0 : acount_reg;
        acount_next = (cur < AngleCountMax) ? cur + AngleCountWidth'(1) : cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            acount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (fin)
            begin
                busy_reg <= 1'b0;
            end
            else if (emit)
            begin
                step_reg <= step_reg + StepWidth'(1);
            end
            if (emit)
            begin
                acount_reg    <= acount_next;
                out_valid_reg <= 1'b1;
            end
            else if (angle.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= job_in;
        end
        if (emit)
        begin
            index_reg  <= cur[IdWidth-1:0];
            first_reg  <= job_reg.nbr[sel.first];
            center_reg <= job_reg.center;
            second_reg <= job_reg.nbr[sel.second];
            fourth_reg <= sel.has_fourth ? job_reg.nbr[sel.fourth] : '0;
            last_reg   <= sel.last;
            ovf_reg    <= cur >= MaxAngles;
        end
    end

    assign angle.valid        = out_valid_reg;
    assign angle.angle_index  = index_reg;
    assign angle.end_first    = first_reg;
    assign angle.center_atom  = center_reg;
    assign angle.end_second   = second_reg;
    assign angle.fourth_atom  = fourth_reg;
    assign angle.last_of_atom = last_reg;
    assign angle.overflow     = ovf_reg;
endmodule
`default_nettype wire
